// ===== rtl/pfi_pkg.sv =====
// ----------------------------------------------------------------------------
// pfi_pkg
// shared constants and types for the polyphase fir interpolator
// ----------------------------------------------------------------------------
package pfi_pkg;

    // default sizes of the filter
    localparam int TAPS_PER_PHASE_DEF = 12;
    localparam int MAX_PHASES_DEF     = 6;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_WIDTH_DEF     = 18;

    // fixed field widths
    localparam int PHASES_W      = 3;
    localparam int PHASE_FIELD_W = 3;
    localparam int TAP_FIELD_W   = 4;

    localparam logic [PHASES_W-1:0] PHASES_RESET = 3'd6;

    // input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic                     hist_write;
        logic                     coef_write;
        logic                     phase_start;
        logic                     tap_issue;
        logic                     result_load;
        logic                     last;
        logic [PHASE_FIELD_W-1:0] phase_index;
    } pfi_cmd_t;

endpackage

// ===== rtl/pfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfi_ctrl
// sequencer: accepts transactions, steps taps and phases, hands off results
// ----------------------------------------------------------------------------
module pfi_ctrl #(
    parameter int TAPS_PER_PHASE = pfi_pkg::TAPS_PER_PHASE_DEF,
    parameter int MAX_PHASES     = pfi_pkg::MAX_PHASES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          kind,
    output logic                          in_stall,
    input  logic                          cfg_we,
    input  logic [pfi_pkg::PHASES_W-1:0]  cfg_data,
    input  logic                          out_free,
    output pfi_pkg::pfi_cmd_t             cmd
);

    localparam int TW = $clog2(TAPS_PER_PHASE);
    localparam int NW = $clog2(MAX_PHASES + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_MAC    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [TW-1:0]                tap_reg, tap_next;
    logic [NW-1:0]                phase_reg, phase_next;
    logic                         drain_reg, drain_next;
    logic [pfi_pkg::PHASES_W-1:0] phases_reg;
    logic [NW-1:0]                n_eff;
    logic                         accept;
    logic                         last_phase;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tap_reg    <= '0;
            phase_reg  <= '0;
            drain_reg  <= 1'b0;
            phases_reg <= pfi_pkg::PHASES_RESET;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
            phase_reg <= phase_next;
            drain_reg <= drain_next;
            if (cfg_we)
            begin
                phases_reg <= cfg_data;
            end
        end
    end

    // zero acts as one, anything above the branch count is clamped
    always_comb
    begin
        if (phases_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(phases_reg) > MAX_PHASES)
        begin
            n_eff = NW'(MAX_PHASES);
        end
        else
        begin
            n_eff = NW'(phases_reg);
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign last_phase = ((phase_reg + NW'(1)) == n_eff);

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        phase_next = phase_reg;
        drain_next = drain_reg;

        cmd             = '0;
        cmd.last        = last_phase;
        cmd.phase_index = pfi_pkg::PHASE_FIELD_W'(phase_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == pfi_pkg::KIND_COEF)
                    begin
                        cmd.coef_write = 1'b1;
                    end
                    else
                    begin
                        cmd.hist_write  = 1'b1;
                        cmd.phase_start = 1'b1;
                        tap_next        = '0;
                        phase_next      = '0;
                        state_next      = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                cmd.tap_issue = 1'b1;
                if (tap_reg == TW'(TAPS_PER_PHASE - 1))
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + TW'(1);
                end
            end
            ST_DRAIN:
            begin
                // let the multiply and accumulate stages empty
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    drain_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    if (last_phase)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.phase_start = 1'b1;
                        tap_next        = '0;
                        phase_next      = phase_reg + NW'(1);
                        state_next      = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pfi_datapath.sv =====
// ----------------------------------------------------------------------------
// pfi_datapath
// history and coefficient memories, mac pipeline, rounding and output register
// ----------------------------------------------------------------------------
module pfi_datapath #(
    parameter int TAPS_PER_PHASE = pfi_pkg::TAPS_PER_PHASE_DEF,
    parameter int MAX_PHASES     = pfi_pkg::MAX_PHASES_DEF,
    parameter int SAMPLE_WIDTH   = pfi_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = pfi_pkg::COEF_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  pfi_pkg::pfi_cmd_t                       cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]          sample_in,
    input  logic [pfi_pkg::PHASE_FIELD_W-1:0]       coef_phase,
    input  logic [pfi_pkg::TAP_FIELD_W-1:0]         coef_tap,
    input  logic signed [COEF_WIDTH-1:0]            coef_value,
    output logic                                    out_free,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]          sample_out,
    output logic [pfi_pkg::PHASE_FIELD_W-1:0]       phase_index,
    output logic                                    last
);

    localparam int TW    = $clog2(TAPS_PER_PHASE);
    localparam int DEPTH = MAX_PHASES * TAPS_PER_PHASE;
    localparam int CAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int AW    = PW + $clog2(TAPS_PER_PHASE);
    localparam int RW    = AW + 1;

    localparam logic signed [RW-1:0] RND     = RW'(1 << (COEF_WIDTH - 3));
    localparam logic signed [RW-1:0] SAT_MAX = RW'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-(2 ** (SAMPLE_WIDTH - 1)));

    // memories
    logic signed [COEF_WIDTH-1:0]   coef_mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] hist_mem [TAPS_PER_PHASE];
    logic [TAPS_PER_PHASE-1:0]      hist_vld_reg;

    // addressing
    logic [TW-1:0]  wp_reg;
    logic [TW-1:0]  wp_inc;
    logic [TW-1:0]  idx_reg;
    logic [CAW-1:0] coef_addr_reg;
    logic [CAW-1:0] coef_waddr;
    logic           coef_in_range;

    // mac pipeline
    logic signed [COEF_WIDTH-1:0]   coef_rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] hist_rd_reg;
    logic                           hist_rd_vld_reg;
    logic                           s1_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] hist_op;
    logic signed [PW-1:0]           prod_next;
    logic signed [PW-1:0]           prod_reg;
    logic                           s2_vld_reg;
    logic signed [AW-1:0]           acc_reg;

    // rounding and saturation
    logic signed [RW-1:0]           rsum;
    logic signed [RW-1:0]           rshift;
    logic signed [SAMPLE_WIDTH-1:0] sat_val;

    // output register
    logic                              out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]    sample_out_reg;
    logic [pfi_pkg::PHASE_FIELD_W-1:0] phase_index_reg;
    logic                              last_reg;

    assign wp_inc = (wp_reg == TW'(TAPS_PER_PHASE - 1)) ? '0 : (wp_reg + TW'(1));

    assign coef_in_range = (32'(coef_phase) < MAX_PHASES) && (32'(coef_tap) < TAPS_PER_PHASE);
    assign coef_waddr    = CAW'(32'(coef_phase) * TAPS_PER_PHASE + 32'(coef_tap));

    // coefficient memory
    always_ff @(posedge clk)
    begin
        if (cmd.coef_write && coef_in_range)
        begin
            coef_mem[coef_waddr] <= coef_value;
        end
        if (cmd.tap_issue)
        begin
            coef_rd_reg <= coef_mem[coef_addr_reg];
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (cmd.hist_write)
        begin
            hist_mem[wp_inc] <= sample_in;
        end
        if (cmd.tap_issue)
        begin
            hist_rd_reg     <= hist_mem[idx_reg];
            hist_rd_vld_reg <= hist_vld_reg[idx_reg];
        end
    end

    // entries never written read as zero
    assign hist_op   = hist_rd_vld_reg ? hist_rd_reg : '0;
    assign prod_next = coef_rd_reg * hist_op;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.phase_start)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + AW'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg  <= '0;
            wp_reg        <= '0;
            idx_reg       <= '0;
            coef_addr_reg <= '0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.tap_issue;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.hist_write)
            begin
                wp_reg               <= wp_inc;
                hist_vld_reg[wp_inc] <= 1'b1;
                coef_addr_reg        <= '0;
            end
            else if (cmd.tap_issue)
            begin
                coef_addr_reg <= coef_addr_reg + CAW'(1);
            end
            if (cmd.phase_start)
            begin
                idx_reg <= cmd.hist_write ? wp_inc : wp_reg;
            end
            else if (cmd.tap_issue)
            begin
                // walk the history newest first
                idx_reg <= (idx_reg == '0) ? TW'(TAPS_PER_PHASE - 1) : (idx_reg - TW'(1));
            end
        end
    end

    // round half up, drop the coefficient fraction, saturate
    assign rsum   = RW'(acc_reg) + RND;
    assign rshift = rsum >>> (COEF_WIDTH - 2);

    always_comb
    begin
        if (rshift > SAT_MAX)
        begin
            sat_val = SAT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (rshift < SAT_MIN)
        begin
            sat_val = SAT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            sat_val = rshift[SAMPLE_WIDTH-1:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            sample_out_reg  <= sat_val;
            phase_index_reg <= cmd.phase_index;
            last_reg        <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign phase_index = phase_index_reg;
    assign last        = last_reg;

endmodule

// ===== rtl/polyphase_fir_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// polyphase_fir_interpolator_unit
// polyphase fir interpolator with a loadable phase-by-tap coefficient table
// ----------------------------------------------------------------------------
// a coefficient transaction (kind = 1) writes one entry of the phase-by-tap
// table; out-of-range addresses are dropped. a sample transaction (kind = 0)
// pushes the sample into the circular history and then produces one result
// per active phase, in phase order, with last set on the final one. one shared
// multiply-accumulate unit walks the taps: per phase it reads one tap per
// cycle out of the coefficient and history memories, lets the multiply and
// accumulate stages empty, and then rounds, saturates and loads the output
// register, waiting while the output side stalls. the input is taken again
// as soon as the last result sits in the output register. the user writes
// phases through cfg_we / cfg_data only while the block is idle; the block
// does not enforce this. 0 acts as 1 and values above MAX_PHASES act as
// MAX_PHASES. coefficients must be written before a sample uses them.
// ----------------------------------------------------------------------------
module polyphase_fir_interpolator_unit #(
    parameter int TAPS_PER_PHASE = pfi_pkg::TAPS_PER_PHASE_DEF,
    parameter int MAX_PHASES     = pfi_pkg::MAX_PHASES_DEF,
    parameter int SAMPLE_WIDTH   = pfi_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = pfi_pkg::COEF_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // configuration
    input  logic                                cfg_we,
    input  logic [pfi_pkg::PHASES_W-1:0]        cfg_data,

    // input transactions
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic signed [SAMPLE_WIDTH-1:0]      sample_in,
    input  logic [pfi_pkg::PHASE_FIELD_W-1:0]   coef_phase,
    input  logic [pfi_pkg::TAP_FIELD_W-1:0]     coef_tap,
    input  logic signed [COEF_WIDTH-1:0]        coef_value,

    // output transactions
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
    output logic [pfi_pkg::PHASE_FIELD_W-1:0]   phase_index,
    output logic                                last
);

    // command bundle from the sequencer, slot status back from the datapath
    pfi_pkg::pfi_cmd_t cmd;
    logic              out_free;

    // sequencer: phase and tap counters, phases register
    pfi_ctrl #(
        .TAPS_PER_PHASE (TAPS_PER_PHASE),
        .MAX_PHASES     (MAX_PHASES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .out_free (out_free),
        .cmd      (cmd)
    );

    // memories, mac pipeline and output register
    pfi_datapath #(
        .TAPS_PER_PHASE (TAPS_PER_PHASE),
        .MAX_PHASES     (MAX_PHASES),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_in   (sample_in),
        .coef_phase  (coef_phase),
        .coef_tap    (coef_tap),
        .coef_value  (coef_value),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .phase_index (phase_index),
        .last        (last)
    );

endmodule
